// ===== src/sfsl_pkg.sv =====
// shared types, constants and the gain table of the state feedback servo law
`default_nettype none
package sfsl_pkg;

  localparam int NUM_SERVOS = 5;
  localparam int OUT_FIELDS = 5;
  localparam int STATE_LEN  = 6;
  localparam int NUM_ACT    = (NUM_SERVOS < OUT_FIELDS) ? NUM_SERVOS : OUT_FIELDS;
  localparam int GAIN_N     = NUM_ACT * STATE_LEN;
  localparam int GIDX_W     = (GAIN_N > 1) ? $clog2(GAIN_N) : 1;
  localparam int COL_W      = $clog2(STATE_LEN);
  localparam int SERVO_W    = (NUM_ACT > 1) ? $clog2(NUM_ACT) : 1;

  // sequencer step plan: three integral products, then the gain products
  localparam int FIRST_GAIN = 3;
  localparam int END_STEP   = FIRST_GAIN + GAIN_N + 1;
  localparam int STEP_W     = $clog2(END_STEP + 1);

  localparam int DATA_W    = 16;
  localparam int SV_W      = 17;
  localparam int A_W       = 17;
  localparam int B_W       = 25;
  localparam int P_W       = A_W + B_W;
  localparam int INTEG_W   = 40;
  localparam int INT_LO_W  = 20;
  localparam int ACC_W     = 60;
  localparam int FRAC_SH   = 28;
  localparam int GAIN_SH   = 16;
  localparam int CFG_IDX_W = 3;

  // servo positions in the result item
  localparam int SERVO_R_AIL  = 0;
  localparam int SERVO_R_STAB = 1;
  localparam int SERVO_L_AIL  = 2;
  localparam int SERVO_L_STAB = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTEGRAL_GAIN = 3'd0,
    REG_STEP_TIME     = 3'd1,
    REG_REF_PITCH     = 3'd2,
    REG_REF_ROLL      = 3'd3,
    REG_REF_YAW       = 3'd4,
    REG_TRIM_R_STAB   = 3'd5,
    REG_TRIM_L_STAB   = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ILO,
    OP_IHI,
    OP_INTEG,
    OP_GAIN
  } mul_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    mul_op_t            op;
    logic [SERVO_W-1:0] servo;
    logic               first;
    logic               last;
  } mul_tag_t;

  typedef struct packed {
    mul_tag_t          tag;
    logic [GIDX_W-1:0] gidx;
    logic [COL_W-1:0]  col;
  } seq_ctrl_t;

  typedef struct packed {
    logic [DATA_W-1:0] integral_gain;
    logic [DATA_W-1:0] step_time;
    logic [DATA_W-1:0] ref_pitch;
    logic [DATA_W-1:0] ref_roll;
    logic [DATA_W-1:0] ref_yaw;
    logic [DATA_W-1:0] trim_r_stab;
    logic [DATA_W-1:0] trim_l_stab;
  } cfg_regs_t;

  localparam logic signed [DATA_W-1:0] GAIN_ROM [OUT_FIELDS*STATE_LEN] = '{
    16'sd0,  16'sd9544, -16'sd2376,  16'sd901,  16'sd3727,     16'sd0,
    16'sd0,  16'sd1106,   16'sd287,  16'sd164,     16'sd0,  16'sd1638,
    16'sd0, -16'sd9544,  16'sd2376, -16'sd901, -16'sd3727,     16'sd0,
    16'sd0,  16'sd3441, -16'sd2212,  16'sd205,  16'sd2580,     16'sd0,
    16'sd0, -16'sd1106,  -16'sd287, -16'sd164,     16'sd0,  16'sd1638
  };

  function automatic logic signed [DATA_W-1:0] gain_at(input logic [GIDX_W-1:0] idx);
    logic signed [DATA_W-1:0] g;
    g = '0;
    if (int'(idx) < GAIN_N) begin
      g = GAIN_ROM[idx];
    end
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== src/sfsl_in_if.sv =====
// input sample channel
`default_nettype none
interface sfsl_in_if;
  logic                      valid;
  logic                      ready;
  logic [sfsl_pkg::DATA_W-1:0] pitch_angle;
  logic [sfsl_pkg::DATA_W-1:0] yaw_angle;
  logic [sfsl_pkg::DATA_W-1:0] roll_angle;
  logic [sfsl_pkg::DATA_W-1:0] rate_x;
  logic [sfsl_pkg::DATA_W-1:0] rate_y;
  logic [sfsl_pkg::DATA_W-1:0] rate_z;

  modport source (output valid, pitch_angle, yaw_angle, roll_angle, rate_x, rate_y, rate_z,
                  input ready);
  modport sink (input valid, pitch_angle, yaw_angle, roll_angle, rate_x, rate_y, rate_z,
                output ready);
endinterface
`default_nettype wire

// ===== src/sfsl_out_if.sv =====
// servo command result channel
`default_nettype none
interface sfsl_out_if;
  logic                      valid;
  logic                      ready;
  logic [sfsl_pkg::DATA_W-1:0] servo_right_aileron;
  logic [sfsl_pkg::DATA_W-1:0] servo_right_stab;
  logic [sfsl_pkg::DATA_W-1:0] servo_left_aileron;
  logic [sfsl_pkg::DATA_W-1:0] servo_rudder;
  logic [sfsl_pkg::DATA_W-1:0] servo_left_stab;

  modport source (output valid, servo_right_aileron, servo_right_stab, servo_left_aileron,
                  servo_rudder, servo_left_stab, input ready);
  modport sink (input valid, servo_right_aileron, servo_right_stab, servo_left_aileron,
                servo_rudder, servo_left_stab, output ready);
endinterface
`default_nettype wire

// ===== src/sfsl_cfg_if.sv =====
// configuration write channel
`default_nettype none
interface sfsl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sfsl_pkg::CFG_IDX_W-1:0] index;
  logic [sfsl_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/sfsl_cfg_regs.sv =====
// configuration register file
`default_nettype none
module sfsl_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sfsl_cfg_if.sink           cfg_ch,
  output sfsl_pkg::cfg_regs_t regs
);

  sfsl_pkg::cfg_regs_t regs_r;
  sfsl_pkg::cfg_regs_t regs_nxt;

  assign cfg_ch.ready = 1'b1;
  assign regs = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        sfsl_pkg::REG_INTEGRAL_GAIN: regs_nxt.integral_gain = cfg_ch.data;
        sfsl_pkg::REG_STEP_TIME:     regs_nxt.step_time     = cfg_ch.data;
        sfsl_pkg::REG_REF_PITCH:     regs_nxt.ref_pitch     = cfg_ch.data;
        sfsl_pkg::REG_REF_ROLL:      regs_nxt.ref_roll      = cfg_ch.data;
        sfsl_pkg::REG_REF_YAW:       regs_nxt.ref_yaw       = cfg_ch.data;
        sfsl_pkg::REG_TRIM_R_STAB:   regs_nxt.trim_r_stab   = cfg_ch.data;
        sfsl_pkg::REG_TRIM_L_STAB:   regs_nxt.trim_l_stab   = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.integral_gain <= 16'hFE66;
      regs_r.step_time     <= 16'd1311;
      regs_r.ref_pitch     <= 16'd0;
      regs_r.ref_roll      <= 16'd0;
      regs_r.ref_yaw       <= 16'd0;
      regs_r.trim_r_stab   <= 16'hFD00;
      regs_r.trim_l_stab   <= 16'hFD00;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/sfsl_mul.sv =====
// shared registered signed multiplier with its operation tag
`default_nettype none
module sfsl_mul (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic signed [sfsl_pkg::A_W-1:0]     a,
  input  wire logic signed [sfsl_pkg::B_W-1:0]     b,
  input  wire sfsl_pkg::mul_tag_t                  tag_in,
  output logic signed      [sfsl_pkg::P_W-1:0]     prod_r,
  output sfsl_pkg::mul_tag_t                       tag_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.op    <= sfsl_pkg::OP_NONE;
      tag_r.servo <= '0;
      tag_r.first <= 1'b0;
      tag_r.last  <= 1'b0;
    end else begin
      tag_r <= tag_in;
    end
  end

endmodule
`default_nettype wire

// ===== src/sfsl_seq.sv =====
// sequencer that steps the shared multiplier through one sample
`default_nettype none
module sfsl_seq (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         out_valid,
  input  wire logic         out_ready,
  output logic              in_ready,
  output logic              load_out,
  output sfsl_pkg::seq_ctrl_t ctrl
);

  sfsl_pkg::seq_state_t state_r, state_nxt;
  logic [sfsl_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [sfsl_pkg::GIDX_W-1:0]  gidx_r, gidx_nxt;
  logic [sfsl_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [sfsl_pkg::SERVO_W-1:0] servo_r, servo_nxt;
  logic                         gain_issue;

  assign gain_issue = (state_r == sfsl_pkg::ST_RUN) &&
                      (step_r >= sfsl_pkg::STEP_W'(sfsl_pkg::FIRST_GAIN)) &&
                      (step_r < sfsl_pkg::STEP_W'(sfsl_pkg::FIRST_GAIN + sfsl_pkg::GAIN_N));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfsl_pkg::ST_IDLE: if (in_valid) state_nxt = sfsl_pkg::ST_RUN;
      sfsl_pkg::ST_RUN: begin
        if (step_r == sfsl_pkg::STEP_W'(sfsl_pkg::END_STEP)) state_nxt = sfsl_pkg::ST_OUT;
      end
      sfsl_pkg::ST_OUT: if (!out_valid || out_ready) state_nxt = sfsl_pkg::ST_IDLE;
      default: state_nxt = sfsl_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = (state_r == sfsl_pkg::ST_IDLE);
    load_out       = (state_r == sfsl_pkg::ST_OUT) && (!out_valid || out_ready);
    ctrl.tag.op    = sfsl_pkg::OP_NONE;
    ctrl.tag.servo = servo_r;
    ctrl.tag.first = (col_r == '0);
    ctrl.tag.last  = (col_r == sfsl_pkg::COL_W'(sfsl_pkg::STATE_LEN - 1));
    ctrl.gidx      = gidx_r;
    ctrl.col       = col_r;
    if (state_r == sfsl_pkg::ST_RUN) begin
      priority if (step_r == sfsl_pkg::STEP_W'(0)) begin
        ctrl.tag.op = sfsl_pkg::OP_ILO;
      end else if (step_r == sfsl_pkg::STEP_W'(1)) begin
        ctrl.tag.op = sfsl_pkg::OP_IHI;
      end else if (step_r == sfsl_pkg::STEP_W'(2)) begin
        ctrl.tag.op = sfsl_pkg::OP_INTEG;
      end else if (gain_issue) begin
        ctrl.tag.op = sfsl_pkg::OP_GAIN;
      end else begin
        ctrl.tag.op = sfsl_pkg::OP_NONE;
      end
    end
  end

  // step and gain-walk counters
  always_comb begin
    step_nxt  = step_r;
    gidx_nxt  = gidx_r;
    col_nxt   = col_r;
    servo_nxt = servo_r;
    if (state_r == sfsl_pkg::ST_IDLE) begin
      step_nxt  = '0;
      gidx_nxt  = '0;
      col_nxt   = '0;
      servo_nxt = '0;
    end else if (state_r == sfsl_pkg::ST_RUN) begin
      step_nxt = step_r + sfsl_pkg::STEP_W'(1);
      if (gain_issue) begin
        gidx_nxt = gidx_r + sfsl_pkg::GIDX_W'(1);
        if (col_r == sfsl_pkg::COL_W'(sfsl_pkg::STATE_LEN - 1)) begin
          col_nxt   = '0;
          servo_nxt = servo_r + sfsl_pkg::SERVO_W'(1);
        end else begin
          col_nxt = col_r + sfsl_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfsl_pkg::ST_IDLE;
      step_r  <= '0;
      gidx_r  <= '0;
      col_r   <= '0;
      servo_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      gidx_r  <= gidx_nxt;
      col_r   <= col_nxt;
      servo_r <= servo_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/state_feedback_servo_law_top.sv =====
// top level of the state feedback servo law with yaw integral action
// usage:
//   in_ch takes one sample per control period: three angles and three body rates.
//   out_ch gives one transaction per sample: the five servo commands, saturated.
//   cfg_ch writes gains, references and trims; it is always ready. The user must
//   write it only while no sample is in flight; the block does not enforce this.
// timing:
//   a sample passes from its transaction to the result register through
//   3 integral products, 30 gain products, the pipeline drain and the load.
//   the time is set by the single 17x25 multiplier, used once per cycle.
//   in_ch is not ready while a sample is being worked on.
// stalls and reset:
//   the result register parts the two sides: a new sample is taken while the
//   previous result waits; the next result is held until out_ch is free.
//   rst_n (synchronous, active low) clears the yaw integral, the sequencer and
//   the output valid, and loads the default register values.
`default_nettype none
module state_feedback_servo_law_top (
  input  wire logic clk,
  input  wire logic rst_n,
  sfsl_in_if.sink   in_ch,
  sfsl_out_if.source out_ch,
  sfsl_cfg_if.sink  cfg_ch
);

  localparam int AW = sfsl_pkg::ACC_W;
  localparam int PW = sfsl_pkg::P_W;
  localparam int DW = sfsl_pkg::DATA_W;

  sfsl_pkg::cfg_regs_t regs;
  sfsl_pkg::seq_ctrl_t ctrl;
  sfsl_pkg::mul_tag_t  tag_r;
  logic                in_ready;
  logic                load_out;
  logic                accept;

  logic signed [sfsl_pkg::A_W-1:0] mul_a;
  logic signed [sfsl_pkg::B_W-1:0] mul_b;
  logic signed [PW-1:0]            prod_r;
  logic signed [DW-1:0]            gain_sel;

  logic signed [sfsl_pkg::SV_W-1:0]    sv_r [sfsl_pkg::STATE_LEN];
  logic signed [DW-1:0]                yaw_r;
  logic signed [sfsl_pkg::INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [AW-1:0]                ilo_r;
  logic signed [AW-1:0]                iterm_r;
  logic signed [AW-1:0]                iterm_neg_r;
  logic signed [AW-1:0]                acc_r;
  logic signed [AW-1:0]                fin_r;
  logic                                fin_v_r;
  logic [sfsl_pkg::SERVO_W-1:0]        fin_servo_r;
  logic signed [DW-1:0]                res_r [sfsl_pkg::NUM_ACT];
  logic signed [DW-1:0]                res_full [sfsl_pkg::OUT_FIELDS];
  logic                                out_valid_r, out_valid_nxt;

  logic signed [AW-1:0]                prod_ext;
  logic signed [AW-1:0]                base;
  logic signed [AW-1:0]                gsum;
  logic signed [sfsl_pkg::INTEG_W:0]   isum;
  logic signed [AW-1:0]                rnd;
  logic signed [AW-sfsl_pkg::FRAC_SH-1:0] quo;
  logic signed [DW-1:0]                sat;

  sfsl_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  sfsl_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_valid (out_valid_r),
    .out_ready (out_ch.ready),
    .in_ready  (in_ready),
    .load_out  (load_out),
    .ctrl      (ctrl)
  );

  sfsl_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .a      (mul_a),
    .b      (mul_b),
    .tag_in (ctrl.tag),
    .prod_r (prod_r),
    .tag_r  (tag_r)
  );

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  // capture the state vector, angle errors formed here
  always_ff @(posedge clk) begin
    if (accept) begin
      sv_r[0] <= $signed({in_ch.pitch_angle[DW-1], in_ch.pitch_angle}) -
                 $signed({regs.ref_pitch[DW-1], regs.ref_pitch});
      sv_r[1] <= $signed({in_ch.roll_angle[DW-1], in_ch.roll_angle}) -
                 $signed({regs.ref_roll[DW-1], regs.ref_roll});
      sv_r[2] <= $signed({in_ch.yaw_angle[DW-1], in_ch.yaw_angle}) -
                 $signed({regs.ref_yaw[DW-1], regs.ref_yaw});
      sv_r[3] <= $signed({in_ch.rate_x[DW-1], in_ch.rate_x});
      sv_r[4] <= $signed({in_ch.rate_y[DW-1], in_ch.rate_y});
      sv_r[5] <= $signed({in_ch.rate_z[DW-1], in_ch.rate_z});
      yaw_r   <= $signed(in_ch.yaw_angle);
    end
  end

  assign gain_sel = sfsl_pkg::gain_at(ctrl.gidx);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.tag.op)
      sfsl_pkg::OP_ILO: begin
        mul_a = $signed({regs.integral_gain[DW-1], regs.integral_gain});
        mul_b = $signed({{(sfsl_pkg::B_W-sfsl_pkg::INT_LO_W){1'b0}},
                         integ_r[sfsl_pkg::INT_LO_W-1:0]});
      end
      sfsl_pkg::OP_IHI: begin
        mul_a = $signed({regs.integral_gain[DW-1], regs.integral_gain});
        mul_b = $signed({{(sfsl_pkg::B_W-(sfsl_pkg::INTEG_W-sfsl_pkg::INT_LO_W))
                          {integ_r[sfsl_pkg::INTEG_W-1]}},
                         integ_r[sfsl_pkg::INTEG_W-1:sfsl_pkg::INT_LO_W]});
      end
      sfsl_pkg::OP_INTEG: begin
        mul_a = $signed({1'b0, regs.step_time});
        mul_b = $signed({{(sfsl_pkg::B_W-DW){yaw_r[DW-1]}}, yaw_r});
      end
      sfsl_pkg::OP_GAIN: begin
        mul_a = $signed({gain_sel[DW-1], gain_sel});
        mul_b = $signed({{(sfsl_pkg::B_W-sfsl_pkg::SV_W){sv_r[ctrl.col][sfsl_pkg::SV_W-1]}},
                         sv_r[ctrl.col]});
      end
      default: ;
    endcase
  end

  assign prod_ext = $signed({{(AW-PW){prod_r[PW-1]}}, prod_r});

  // starting value of a servo sum: integral term on the ailerons, trim on the stabilisers
  always_comb begin
    base = '0;
    unique case (int'(tag_r.servo))
      sfsl_pkg::SERVO_R_AIL:  base = iterm_r;
      sfsl_pkg::SERVO_L_AIL:  base = iterm_neg_r;
      sfsl_pkg::SERVO_R_STAB: base = $signed({{(AW-DW-sfsl_pkg::FRAC_SH)
                                               {regs.trim_r_stab[DW-1]}},
                                              regs.trim_r_stab,
                                              {sfsl_pkg::FRAC_SH{1'b0}}});
      sfsl_pkg::SERVO_L_STAB: base = $signed({{(AW-DW-sfsl_pkg::FRAC_SH)
                                               {regs.trim_l_stab[DW-1]}},
                                              regs.trim_l_stab,
                                              {sfsl_pkg::FRAC_SH{1'b0}}});
      default: base = '0;
    endcase
  end

  assign gsum = (tag_r.first ? base : acc_r) + (prod_ext <<< sfsl_pkg::GAIN_SH);

  // integral update with saturation at 40 bits
  always_comb begin
    isum = $signed({integ_r[sfsl_pkg::INTEG_W-1], integ_r}) +
           $signed(prod_r[sfsl_pkg::INTEG_W:0]);
    integ_nxt = isum[sfsl_pkg::INTEG_W-1:0];
    if (isum[sfsl_pkg::INTEG_W] != isum[sfsl_pkg::INTEG_W-1]) begin
      integ_nxt = isum[sfsl_pkg::INTEG_W] ?
                  $signed({1'b1, {(sfsl_pkg::INTEG_W-1){1'b0}}}) :
                  $signed({1'b0, {(sfsl_pkg::INTEG_W-1){1'b1}}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (tag_r.op == sfsl_pkg::OP_INTEG) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iterm_neg_r <= -iterm_r;
    unique case (tag_r.op)
      sfsl_pkg::OP_ILO: ilo_r   <= prod_ext;
      sfsl_pkg::OP_IHI: iterm_r <= ilo_r + (prod_ext <<< sfsl_pkg::INT_LO_W);
      sfsl_pkg::OP_GAIN: begin
        if (tag_r.last) begin
          fin_r       <= gsum;
          fin_servo_r <= tag_r.servo;
        end else begin
          acc_r <= gsum;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else begin
      fin_v_r <= (tag_r.op == sfsl_pkg::OP_GAIN) && tag_r.last;
    end
  end

  // round half up to 1/64 degree, then saturate
  always_comb begin
    rnd = fin_r + $signed({{(AW-sfsl_pkg::FRAC_SH){1'b0}}, 1'b1,
                           {(sfsl_pkg::FRAC_SH-1){1'b0}}});
    quo = rnd[AW-1:sfsl_pkg::FRAC_SH];
    priority if (quo > $signed((AW-sfsl_pkg::FRAC_SH)'(32767))) begin
      sat = 16'sh7FFF;
    end else if (quo < $signed((AW-sfsl_pkg::FRAC_SH)'(-32768))) begin
      sat = -16'sh8000;
    end else begin
      sat = quo[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_v_r) begin
      res_r[fin_servo_r] <= sat;
    end
  end

  for (genvar s = 0; s < sfsl_pkg::OUT_FIELDS; s++) begin : g_res
    if (s < sfsl_pkg::NUM_ACT) begin : g_on
      assign res_full[s] = res_r[s];
    end else begin : g_off
      assign res_full[s] = '0;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.servo_right_aileron <= res_full[0];
      out_ch.servo_right_stab    <= res_full[1];
      out_ch.servo_left_aileron  <= res_full[2];
      out_ch.servo_rudder        <= res_full[3];
      out_ch.servo_left_stab     <= res_full[4];
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule
`default_nettype wire

// ===== dv/tb_state_feedback_servo_law_top.sv =====
// testbench of the state feedback servo law: random samples checked against a predictor
`timescale 1ns / 1ps
module tb_state_feedback_servo_law_top;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 800;
  localparam int MAX_REPORTS  = 10;
  localparam int SERVO_COUNT  = 5;
  localparam int STATE_COUNT  = 6;
  localparam logic [sfsl_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam longint INTEG_MAX = 64'sd549755813887;
  localparam longint INTEG_MIN = -64'sd549755813888;

  // Q4.12 gain rows: right aileron, right stab, left aileron, rudder, left stab
  localparam int SERVO_GAIN [SERVO_COUNT*STATE_COUNT] = '{
    0,  9544, -2376,  901,  3727,    0,
    0,  1106,   287,  164,     0, 1638,
    0, -9544,  2376, -901, -3727,    0,
    0,  3441, -2212,  205,  2580,    0,
    0, -1106,  -287, -164,     0, 1638
  };

  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] roll;
    logic [15:0] rate_x;
    logic [15:0] rate_y;
    logic [15:0] rate_z;
  } sample_t;

  typedef logic [SERVO_COUNT-1:0][15:0] servo_cmds_t;

  typedef enum {YAW_ANY, YAW_HIGH, YAW_LOW} yaw_drift_t;
  typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  class servo_cmd_checker;
    logic signed [15:0] integral_gain;
    logic [15:0]        step_time;
    logic signed [15:0] ref_pitch;
    logic signed [15:0] ref_roll;
    logic signed [15:0] ref_yaw;
    logic signed [15:0] trim_r_stab;
    logic signed [15:0] trim_l_stab;
    longint             yaw_integral;
    servo_cmds_t        expected_cmds [$];
    int                 mismatches;
    string              servo_label [SERVO_COUNT];

    function new();
      integral_gain = -16'sd410;
      step_time     = 16'd1311;
      ref_pitch     = '0;
      ref_roll      = '0;
      ref_yaw       = '0;
      trim_r_stab   = -16'sd768;
      trim_l_stab   = -16'sd768;
      yaw_integral  = 0;
      mismatches    = 0;
      servo_label   = '{"right_aileron", "right_stab", "left_aileron", "rudder", "left_stab"};
    endfunction

    function void write_reg(logic [sfsl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        sfsl_pkg::REG_INTEGRAL_GAIN: integral_gain = data;
        sfsl_pkg::REG_STEP_TIME:     step_time = data;
        sfsl_pkg::REG_REF_PITCH:     ref_pitch = data;
        sfsl_pkg::REG_REF_ROLL:      ref_roll = data;
        sfsl_pkg::REG_REF_YAW:       ref_yaw = data;
        sfsl_pkg::REG_TRIM_R_STAB:   trim_r_stab = data;
        sfsl_pkg::REG_TRIM_L_STAB:   trim_l_stab = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    // works out the five commands for a sample and advances the yaw integral
    function void note_sample(sample_t s);
      longint      err [STATE_COUNT];
      longint      iterm;
      longint      trim;
      longint      acc;
      longint      r;
      int          active;
      servo_cmds_t cmd;
      active = (sfsl_pkg::NUM_SERVOS < SERVO_COUNT) ? sfsl_pkg::NUM_SERVOS : SERVO_COUNT;
      err[0] = longint'($signed(s.pitch)) - longint'(ref_pitch);
      err[1] = longint'($signed(s.roll)) - longint'(ref_roll);
      err[2] = longint'($signed(s.yaw)) - longint'(ref_yaw);
      err[3] = longint'($signed(s.rate_x));
      err[4] = longint'($signed(s.rate_y));
      err[5] = longint'($signed(s.rate_z));
      // integral term uses the value from before this sample
      iterm = longint'(integral_gain) * yaw_integral;
      yaw_integral = yaw_integral + longint'(step_time) * longint'($signed(s.yaw));
      if (yaw_integral > INTEG_MAX) yaw_integral = INTEG_MAX;
      if (yaw_integral < INTEG_MIN) yaw_integral = INTEG_MIN;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        cmd[i] = '0;
        if (i < active) begin
          acc = 0;
          for (int j = 0; j < STATE_COUNT; j++) begin
            acc += longint'(SERVO_GAIN[i*STATE_COUNT+j]) * err[j];
          end
          trim = (i == sfsl_pkg::SERVO_R_STAB) ? longint'(trim_r_stab) :
                 (i == sfsl_pkg::SERVO_L_STAB) ? longint'(trim_l_stab) : 0;
          acc = acc * 65536 + trim * (64'sd1 <<< 28);
          if (i == sfsl_pkg::SERVO_R_AIL) begin
            acc += iterm;
          end else if (i == sfsl_pkg::SERVO_L_AIL) begin
            acc -= iterm;
          end
          // round half up to 1/64 degree
          r = (acc + (64'sd1 <<< 27)) >>> 28;
          if (r > 32767) r = 32767;
          if (r < -32768) r = -32768;
          cmd[i] = r[15:0];
        end
      end
      expected_cmds.push_back(cmd);
    endfunction

    function void check_cmds(servo_cmds_t got);
      servo_cmds_t want;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] servo transaction with no sample pending", $time);
        end
        return;
      end
      want = expected_cmds.pop_front();
      for (int i = 0; i < SERVO_COUNT; i++) begin
        if (got[i] !== want[i]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %0d, got %0d", $time, servo_label[i],
                     $signed(want[i]), $signed(got[i]));
          end
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  int               cmds_taken;
  int unsigned      cycle_count;
  servo_cmd_checker law_check;

  sfsl_in_if  in_ch ();
  sfsl_out_if out_ch ();
  sfsl_cfg_if cfg_ch ();

  state_feedback_servo_law_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(11))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4:       return 16'($urandom_range(64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample(yaw_drift_t drift);
    sample_t s;
    s.pitch  = pick16();
    s.roll   = pick16();
    s.rate_x = pick16();
    s.rate_y = pick16();
    s.rate_z = pick16();
    s.yaw    = pick16();
    // push the integral towards one of its limits
    if (drift == YAW_HIGH && $urandom_range(9) != 0) s.yaw = 16'h7fff;
    if (drift == YAW_LOW && $urandom_range(9) != 0) s.yaw = 16'h8000;
    return s;
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic put_sample(input sample_t s);
    in_ch.valid       <= 1'b1;
    in_ch.pitch_angle <= s.pitch;
    in_ch.yaw_angle   <= s.yaw;
    in_ch.roll_angle  <= s.roll;
    in_ch.rate_x      <= s.rate_x;
    in_ch.rate_y      <= s.rate_y;
    in_ch.rate_z      <= s.rate_z;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    law_check.note_sample(s);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [sfsl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    law_check.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] gain, input logic [15:0] dt,
                            input logic [15:0] rp, input logic [15:0] rr,
                            input logic [15:0] ry, input logic [15:0] trs,
                            input logic [15:0] tls);
    while (law_check.pending() != 0) @(posedge clk);
    @(negedge clk);
    write_cfg(sfsl_pkg::REG_INTEGRAL_GAIN, gain);
    write_cfg(sfsl_pkg::REG_STEP_TIME, dt);
    write_cfg(sfsl_pkg::REG_REF_PITCH, rp);
    write_cfg(sfsl_pkg::REG_REF_ROLL, rr);
    write_cfg(sfsl_pkg::REG_REF_YAW, ry);
    write_cfg(sfsl_pkg::REG_TRIM_R_STAB, trs);
    write_cfg(sfsl_pkg::REG_TRIM_L_STAB, tls);
    // unmapped index, must leave every register alone
    write_cfg(REG_SPARE, pick16());
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input int count, input yaw_drift_t drift);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(24, 1);
      for (int k = 0; k < burst && sent < count; k++) begin
        put_sample(random_sample(drift));
        sent++;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      law_check.check_cmds({out_ch.servo_left_stab, out_ch.servo_rudder,
                            out_ch.servo_left_aileron, out_ch.servo_right_stab,
                            out_ch.servo_right_aileron});
      cmds_taken++;
    end
  end

  initial begin : rx_side
    int       stretch;
    rx_mode_t mode;
    bit       held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      stretch = $urandom_range(80, 1);
      mode = rx_mode_t'($urandom_range(3));
      repeat (stretch) begin
        @(negedge clk);
        if (!held && cmds_taken >= HOLD_AFTER) begin
          // long back-pressure so that the block fills and stalls its input
          held = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
          case (mode)
            RX_FREE:   out_ch.ready <= 1'b1;
            RX_HALF:   out_ch.ready <= 1'($urandom_range(1));
            RX_SPARSE: out_ch.ready <= ($urandom_range(3) == 0);
            default:   out_ch.ready <= ($urandom_range(9) != 0);
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** state_feedback_servo_law_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    law_check = new();
    cmds_taken = 0;
    rst_n <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.pitch_angle <= '0;
    in_ch.yaw_angle   <= '0;
    in_ch.roll_angle  <= '0;
    in_ch.rate_x      <= '0;
    in_ch.rate_y      <= '0;
    in_ch.rate_z      <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes and bit patterns at the reset settings
    put_sample('0);
    put_sample({6{16'h7fff}});
    put_sample({6{16'h8000}});
    put_sample({6{16'hffff}});
    put_sample({6{16'h0001}});
    put_sample({3{16'h5555, 16'haaaa}});
    put_sample({3{16'haaaa, 16'h5555}});
    for (int f = 0; f < STATE_COUNT; f++) begin
      put_sample(sample_t'(96'h7fff << (16 * f)));
      put_sample(sample_t'(96'h8000 << (16 * f)));
    end
    run_phase(181, YAW_ANY);

    set_config(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(), pick16());
    run_phase(180, YAW_ANY);
    // drive the integral into its upper limit, then across to the lower one
    set_config(16'h7fff, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    run_phase(360, YAW_HIGH);
    set_config(16'h8000, 16'hffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    run_phase(650, YAW_LOW);
    set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_phase(150, YAW_ANY);
    set_config(16'h0001, 16'h0001, pick16(), pick16(), pick16(), pick16(), pick16());
    run_phase(150, YAW_ANY);
    set_config(16'hfe66, 16'h051f, 16'h0000, 16'h0000, 16'h0000, 16'hfd00, 16'hfd00);
    run_phase(150, YAW_ANY);
    set_config(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(), pick16());
    run_phase(110, YAW_ANY);

    while (law_check.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (law_check.mismatches == 0) begin
      $display("** state_feedback_servo_law_top: PASSED **");
    end else begin
      $display("** state_feedback_servo_law_top: FAILED **");
    end
    $finish;
  end

endmodule
